// ----- src/ncc_pkg.sv -----
`default_nettype none

package ncc_pkg;

  // class and vector geometry
  localparam int NUM_CENTROIDS = 4;
  localparam int VECTOR_DIMS   = 16;

  // field widths
  localparam int CLASS_W = 2;
  localparam int DIM_W   = 4;
  localparam int CVAL_W  = 16;
  localparam int CODE_W  = 12;
  localparam int ACC_W   = 36;
  localparam int SQ_W    = 2 * CVAL_W;

  // coordinate index width inside one cell
  localparam int DIDX_W = (VECTOR_DIMS > 1) ? $clog2(VECTOR_DIMS) : 1;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // input kind codes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // word travelling along the cell chain
  typedef struct packed {
    logic               is_wr;
    logic               is_smp;
    logic               is_last;
    logic [CLASS_W-1:0] cls;
    logic [DIDX_W-1:0]  dim;
    logic [CVAL_W-1:0]  cval;
    logic [CVAL_W-1:0]  scaled;
    logic [CLASS_W-1:0] best_lbl;
    logic [ACC_W-1:0]   best_dist;
  } tok_t;

endpackage

`default_nettype wire

// ----- src/ncc_cell.sv -----
`default_nettype none

module ncc_cell import ncc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic [CLASS_W-1:0] cell_id,
  input  wire logic               tin_vld,
  input  wire tok_t               tin,
  output logic                    tout_vld,
  output tok_t                    tout
);

  // this class's centroid coordinates
  logic [CVAL_W-1:0] coord_r [VECTOR_DIMS];

  logic              a_vld_r, a_vld_nxt;
  tok_t              a_r;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic              b_vld_r, b_vld_nxt;
  tok_t              b_r, b_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  logic [CVAL_W-1:0] ref_val;
  logic [CVAL_W-1:0] diff;
  logic [ACC_W:0]    sum_wide;
  logic [ACC_W-1:0]  sum_sat;

  // stage a: coordinate read and squared difference
  always_comb begin
    ref_val = coord_r[tin.dim];
    diff    = (tin.scaled >= ref_val) ? (tin.scaled - ref_val) : (ref_val - tin.scaled);
    sq_nxt  = SQ_W'(diff) * SQ_W'(diff);
    a_vld_nxt = en ? tin_vld : a_vld_r;
  end

  // coordinate store, written as the word passes
  always_ff @(posedge clk) begin
    if (en && tin_vld && tin.is_wr && (tin.cls == cell_id)) begin
      coord_r[tin.dim] <= tin.cval;
    end
  end

  // stage b: saturating accumulate and running minimum
  always_comb begin
    sum_wide = {1'b0, acc_r} + (ACC_W + 1)'(sq_r);
    sum_sat  = sum_wide[ACC_W] ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];
    b_nxt    = a_r;
    acc_nxt  = acc_r;
    if (a_vld_r && a_r.is_smp) begin
      acc_nxt = sum_sat;
      if (a_r.is_last) begin
        acc_nxt = '0;
        if (sum_sat < a_r.best_dist) begin
          b_nxt.best_dist = sum_sat;
          b_nxt.best_lbl  = cell_id;
        end
      end
    end
    b_vld_nxt = en ? a_vld_r : b_vld_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      if (en) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= tin;
      sq_r <= sq_nxt;
      b_r  <= b_nxt;
    end
  end

  assign tout_vld = b_vld_r;
  assign tout     = b_r;

endmodule

`default_nettype wire

// ----- src/nearest_centroid_classifier_core.sv -----
// after the last sample is taken, its result word passes the two register stages in each
// class cell in turn, then the output slot register
// throughput: one input word per cycle; results leave through a two-word output buffer,
// so in_tready drops only while two result words wait
// reset (rst_n, synchronous, active low) clears accumulators, valid flags and the buffer;
// centroid coordinates are undefined until written
`default_nettype none

module nearest_centroid_classifier_core import ncc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [1:0] class_index, [5:2] dim_index, [21:6] centroid_value, [33:22] sample_code
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [1:0] class_label, [37:2] best_distance
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic               en;
  logic [CLASS_W-1:0] in_cls;
  logic [DIM_W-1:0]   in_dim;
  logic [CVAL_W-1:0]  in_cval;
  logic [CODE_W-1:0]  in_code;
  logic               dim_ok;
  tok_t               tok_in;

  logic               vld [NUM_CENTROIDS+1];
  tok_t               tok [NUM_CENTROIDS+1];

  logic               out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0] lbl_r, lbl_nxt;
  logic [ACC_W-1:0]   dist_r, dist_nxt;
  logic               skid_vld_r, skid_vld_nxt;
  logic [CLASS_W-1:0] skid_lbl_r, skid_lbl_nxt;
  logic [ACC_W-1:0]   skid_dist_r, skid_dist_nxt;
  logic               res_new;
  logic               out_pop;

  // chain advances while the second output slot is free
  assign en        = !skid_vld_r;
  assign in_tready = en;

  // unpack the input word
  assign in_cls  = in_tdata[1:0];
  assign in_dim  = in_tdata[5:2];
  assign in_cval = in_tdata[21:6];
  assign in_code = in_tdata[33:22];
  assign dim_ok  = 32'(in_dim) < VECTOR_DIMS;

  // build the word that enters the first cell
  always_comb begin
    tok_in.is_wr     = (in_tuser == KIND_WRITE) && dim_ok && (32'(in_cls) < NUM_CENTROIDS);
    tok_in.is_smp    = (in_tuser == KIND_SAMPLE) && dim_ok;
    tok_in.is_last   = (in_tuser == KIND_SAMPLE) && (32'(in_dim) == VECTOR_DIMS - 1);
    tok_in.cls       = in_cls;
    tok_in.dim       = DIDX_W'(in_dim);
    tok_in.cval      = in_cval;
    tok_in.scaled    = {in_code, 4'b0000};
    tok_in.best_lbl  = '0;
    tok_in.best_dist = {ACC_W{1'b1}};
  end

  assign vld[0] = in_tvalid;
  assign tok[0] = tok_in;

  // one cell per class
  for (genvar c = 0; c < NUM_CENTROIDS; c++) begin : g_cell
    ncc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_id  (CLASS_W'(c)),
      .tin_vld  (vld[c]),
      .tin      (tok[c]),
      .tout_vld (vld[c+1]),
      .tout     (tok[c+1])
    );
  end

  // two-word output buffer: output slot plus overflow slot
  always_comb begin
    res_new       = en && vld[NUM_CENTROIDS] && tok[NUM_CENTROIDS].is_last;
    out_pop       = out_valid_r && out_tready;
    out_valid_nxt = out_valid_r;
    lbl_nxt       = lbl_r;
    dist_nxt      = dist_r;
    skid_vld_nxt  = skid_vld_r;
    skid_lbl_nxt  = skid_lbl_r;
    skid_dist_nxt = skid_dist_r;
    if (skid_vld_r) begin
      if (out_pop) begin
        lbl_nxt      = skid_lbl_r;
        dist_nxt     = skid_dist_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_pop) begin
      out_valid_nxt = res_new;
      lbl_nxt       = tok[NUM_CENTROIDS].best_lbl;
      dist_nxt      = tok[NUM_CENTROIDS].best_dist;
    end else if (res_new) begin
      skid_vld_nxt  = 1'b1;
      skid_lbl_nxt  = tok[NUM_CENTROIDS].best_lbl;
      skid_dist_nxt = tok[NUM_CENTROIDS].best_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lbl_r       <= lbl_nxt;
    dist_r      <= dist_nxt;
    skid_lbl_r  <= skid_lbl_nxt;
    skid_dist_r <= skid_dist_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - CLASS_W - ACC_W)'(0), dist_r, lbl_r};

endmodule

`default_nettype wire

// ----- bench/nearest_centroid_classifier_core_tb.sv -----
`timescale 1ns / 1ps

module nearest_centroid_classifier_core_tb;
  import ncc_pkg::*;

  localparam int TOTAL_WORDS = 1050;
  localparam int CALM_WORDS  = 150;
  localparam int LATENCY     = 2 * NUM_CENTROIDS;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // bit positions inside in_tdata
  localparam int DIM_LSB  = CLASS_W;
  localparam int CVAL_LSB = DIM_LSB + DIM_W;
  localparam int CODE_LSB = CVAL_LSB + CVAL_W;

  typedef struct packed {
    logic               kind;
    logic [CLASS_W-1:0] cls;
    logic [DIM_W-1:0]   dim;
    logic [CVAL_W-1:0]  cval;
    logic [CODE_W-1:0]  code;
  } in_word_t;

  typedef struct packed {
    logic [CLASS_W-1:0] label;
    logic [ACC_W-1:0]   distance;
  } verdict_t;

  // predicts classifier verdicts and checks them in order
  class centroid_scoreboard;
    logic [CVAL_W-1:0] coords [NUM_CENTROIDS*VECTOR_DIMS];
    logic [ACC_W-1:0]  sums [NUM_CENTROIDS];
    verdict_t          pending [$];
    int                errors;

    function new();
      foreach (coords[i]) coords[i] = '0;
      foreach (sums[i]) sums[i] = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    // apply one accepted input word to the shadow state
    function void note_word(in_word_t w);
      logic [CVAL_W-1:0] scaled;
      logic [CVAL_W-1:0] coord;
      logic [CVAL_W-1:0] diff;
      logic [SQ_W-1:0]   sq;
      logic [ACC_W:0]    total;
      verdict_t          v;
      int                c;
      if (w.kind == KIND_WRITE) begin
        if (w.cls < NUM_CENTROIDS && w.dim < VECTOR_DIMS)
          coords[w.cls * VECTOR_DIMS + w.dim] = w.cval;
        return;
      end
      if (w.dim >= VECTOR_DIMS) return;
      // code to 12.4, then saturating square-and-add per class
      scaled = {w.code, 4'b0000};
      for (c = 0; c < NUM_CENTROIDS; c++) begin
        coord = coords[c * VECTOR_DIMS + w.dim];
        diff  = (scaled >= coord) ? scaled - coord : coord - scaled;
        sq    = diff * diff;
        total = sums[c] + sq;
        sums[c] = (total > {1'b0, ACC_MAX}) ? ACC_MAX : total[ACC_W-1:0];
      end
      if (w.dim != VECTOR_DIMS - 1) return;
      // strict less-than keeps the lowest index on ties
      v.label    = '0;
      v.distance = sums[0];
      for (c = 1; c < NUM_CENTROIDS; c++) begin
        if (sums[c] < v.distance) begin
          v.distance = sums[c];
          v.label    = CLASS_W'(c);
        end
      end
      pending.push_back(v);
      foreach (sums[i]) sums[i] = '0;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      verdict_t got;
      verdict_t want;
      got.label    = data[CLASS_W-1:0];
      got.distance = data[CLASS_W +: ACC_W];
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result word: label %0d distance %0d",
                       got.label, got.distance));
        return;
      end
      want = pending.pop_front();
      if (got.label !== want.label || got.distance !== want.distance)
        flag($sformatf("result mismatch: expected label %0d distance %0d, got label %0d distance %0d",
                       want.label, want.distance, got.label, got.distance));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  centroid_scoreboard board;
  int sent;
  int send_idle_pct;
  int stall_count;
  bit calm;
  bit hold_req;

  nearest_centroid_classifier_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // centroid coordinate write, unused code bits randomised
  function automatic in_word_t coord_word(int cls, int dim, logic [CVAL_W-1:0] val);
    in_word_t w;
    w.kind = KIND_WRITE;
    w.cls  = CLASS_W'(cls);
    w.dim  = DIM_W'(dim);
    w.cval = val;
    w.code = CODE_W'($urandom);
    return w;
  endfunction

  // sample word, unused class and coordinate bits randomised
  function automatic in_word_t sample_word(int dim, logic [CODE_W-1:0] code);
    in_word_t w;
    w.kind = KIND_SAMPLE;
    w.cls  = CLASS_W'($urandom);
    w.dim  = DIM_W'(dim);
    w.cval = CVAL_W'($urandom);
    w.code = code;
    return w;
  endfunction

  function automatic logic [CODE_W-1:0] any_code();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CVAL_W-1:0] any_cval();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CVAL_W'($urandom);
    endcase
  endfunction

  // code close to one class's coordinate, so that class tends to win
  function automatic logic [CODE_W-1:0] code_near(int cls, int dim);
    int v;
    v = int'(board.coords[cls * VECTOR_DIMS + dim] >> 4) + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > (1 << CODE_W) - 1) v = (1 << CODE_W) - 1;
    return CODE_W'(v);
  endfunction

  // offer one word from a falling edge, return at the falling edge after acceptance
  task automatic send_word(input in_word_t w);
    int gap;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 10);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = w.kind;
    in_tdata  = IN_DATA_W'({w.code, w.cval, w.dim, w.cls});
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin
    int gap;
    int pct;
    int span;
    out_tready = 1'b0;
    pct  = 0;
    span = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (span == 0) begin
        pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        span = $urandom_range(20, 120);
      end
      span--;
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready = 1'b1;
        hold_req   = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < pct) begin
        out_tready = 1'b0;
        gap = $urandom_range(1, 10);
        repeat (gap) @(negedge clk);
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // both handshakes sampled at the rising edge, plus the stall watchdog
  always @(posedge clk) begin : monitor
    in_word_t seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        seen.kind = in_tuser;
        seen.cls  = in_tdata[CLASS_W-1:0];
        seen.dim  = in_tdata[DIM_LSB +: DIM_W];
        seen.cval = in_tdata[CVAL_LSB +: CVAL_W];
        seen.code = in_tdata[CODE_LSB +: CODE_W];
        board.note_word(seen);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("nearest_centroid_classifier_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int  c;
    int  d;
    int  t;
    int  n;
    int  pick;
    bit  near;
    bit  pressed;
    board         = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = KIND_WRITE;
    sent          = 0;
    send_idle_pct = 0;
    stall_count   = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    pressed       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load every coordinate before any sample; dim 0 at full scale, last dim mid-scale
    for (c = 0; c < NUM_CENTROIDS; c++)
      for (d = 0; d < VECTOR_DIMS; d++)
        send_word(coord_word(c, d, (d == 0) ? 16'hFFFF :
                                   (d == VECTOR_DIMS - 1) ? 16'h8000 : any_cval()));

    // single-sample vectors: every class ties, label 0 wins
    send_word(sample_word(VECTOR_DIMS - 1, 12'h800));
    send_word(sample_word(VECTOR_DIMS - 1, 12'h000));
    // class 3 exact at full-scale code, class 2 at zero coordinate
    send_word(coord_word(3, VECTOR_DIMS - 1, 16'hFFF0));
    send_word(coord_word(2, VECTOR_DIMS - 1, 16'h0000));
    send_word(sample_word(VECTOR_DIMS - 1, 12'hFFF));
    // samples out of order, only the last dimension closes the vector
    send_word(sample_word(7, any_code()));
    send_word(sample_word(2, any_code()));
    send_word(sample_word(VECTOR_DIMS - 1, any_code()));
    // repeated worst-case dim 0 drives every accumulator into saturation
    repeat (17) send_word(sample_word(0, 12'h000));
    send_word(sample_word(VECTOR_DIMS - 1, 12'h000));

    // random traffic, mostly whole vectors
    while (sent < TOTAL_WORDS) begin
      if (!pressed && sent >= TOTAL_WORDS / 2) begin
        hold_req = 1'b1;
        pressed  = 1'b1;
      end
      if (sent >= TOTAL_WORDS - CALM_WORDS) calm = 1'b1;
      case ($urandom_range(0, 3))
        0, 1: send_idle_pct = 0;
        2: send_idle_pct = 10;
        default: send_idle_pct = 30;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        t    = $urandom_range(0, NUM_CENTROIDS - 1);
        near = $urandom_range(0, 1);
        for (d = 0; d < VECTOR_DIMS; d++)
          send_word(sample_word(d, near ? code_near(t, d) : any_code()));
      end else if (pick < 78) begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_word(coord_word($urandom_range(0, NUM_CENTROIDS - 1),
                               $urandom_range(0, VECTOR_DIMS - 1), any_cval()));
      end else if (pick < 92) begin
        n = $urandom_range(0, 6);
        repeat (n) send_word(sample_word($urandom_range(0, VECTOR_DIMS - 2), any_code()));
        send_word(sample_word(VECTOR_DIMS - 1, any_code()));
      end else begin
        // stray samples that carry over into the next vector
        n = $urandom_range(1, 4);
        repeat (n) send_word(sample_word($urandom_range(0, VECTOR_DIMS - 2), any_code()));
      end
    end
    in_tvalid = 1'b0;

    // drain, then a quiet tail to catch stray result words
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (board.errors == 0)
      $display("nearest_centroid_classifier_core_tb OK");
    else
      $display("nearest_centroid_classifier_core_tb NOT OK");
    $finish;
  end

endmodule
